// ----- rtl/bml_pkg.sv -----
// Shared constants, types and field arithmetic of the Berlekamp-Massey locator.
`default_nettype none

package bml_pkg;

  localparam int unsigned T_MAX      = 128;
  localparam int unsigned FIELD_BITS = 13;

  localparam int unsigned NPOLY = T_MAX + 1;
  localparam int unsigned NSYN  = 2 * T_MAX;
  localparam int unsigned PAW   = $clog2(NPOLY);
  localparam int unsigned SAW   = $clog2(NSYN);
  localparam int unsigned MW    = $clog2(FIELD_BITS + 1);
  localparam int unsigned TW    = 8;
  localparam int unsigned CW    = 9;
  localparam int unsigned CFG_W = FIELD_BITS + 1;

  localparam logic [CFG_W-1:0] POLY_RST = CFG_W'(8219);
  localparam logic [MW-1:0]    DEG_RST  = MW'(13);
  localparam logic [TW-1:0]    TCAP_RST = TW'(128);

  typedef enum logic [1:0] {
    CFG_POLY   = 2'd0,
    CFG_DEGREE = 2'd1,
    CFG_TCAP   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DISC,
    ST_DECIDE,
    ST_INV,
    ST_KMUL,
    ST_CORR
  } state_e;

  // Shift-and-reduce product, MSB of b first, operands masked to m bits.
  function automatic logic [FIELD_BITS-1:0] gf_mul(
    input logic [FIELD_BITS-1:0] a,
    input logic [FIELD_BITS-1:0] b,
    input logic [FIELD_BITS:0]   poly,
    input logic [MW-1:0]         m
  );
    logic [FIELD_BITS:0]   r;
    logic [FIELD_BITS:0]   one_sh;
    logic [FIELD_BITS-1:0] mask;
    logic [FIELD_BITS-1:0] am;
    logic [FIELD_BITS-1:0] bm;
    one_sh = (FIELD_BITS + 1)'(1) << m;
    mask   = FIELD_BITS'(one_sh - 1'b1);
    am     = a & mask;
    bm     = b & mask;
    r      = '0;
    for (int k = FIELD_BITS - 1; k >= 0; k--) begin
      if (k < int'(m)) begin
        r = r << 1;
        if (r[m]) r = r ^ poly;
        r = r & {1'b0, mask};
        if (bm[k]) r = r ^ {1'b0, am};
      end
    end
    return r[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/berlekamp_massey_locator_core.sv -----
// Top level of the Berlekamp-Massey error locator over GF(2^m).
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------------
//  request   | start_i & !busy_o       | req_type_i start_req_i syndrome_value_i
//            |                         | coeff_index_i
//  result    | res_valid_o (1 cycle)   | coefficient_o lfsr_length_o done_res_o
//            |                         | bad_index_o
//  config    | cfg_we_i                | cfg_idx_i cfg_data_i
//
// A read beat holds busy through the read state only; its result strobes in the cycle after it.
// A push beat holds busy through discrepancy and decision; when the discrepancy is nonzero,
// it goes on to inversion on the shared GF multiplier, the k product and correction, one
// polynomial entry per cycle through the bank RAMs.
// A push dropped after done never raises busy.
// Reset (async, active low) restores the config defaults and the C=1, B=1 start state;
// the polynomial banks carry per-entry valid bits, so no clearing pass is needed.
// The receiver cannot stall: each result beat shows for exactly one cycle.
`default_nettype none

module berlekamp_massey_locator_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 req_type_i,
  input  wire logic                                 start_req_i,
  input  wire logic [bml_pkg::FIELD_BITS-1:0]       syndrome_value_i,
  input  wire logic [bml_pkg::TW-1:0]               coeff_index_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [1:0]                           cfg_idx_i,
  input  wire logic [bml_pkg::CFG_W-1:0]            cfg_data_i,
  output logic                                      res_valid_o,
  output logic      [bml_pkg::FIELD_BITS-1:0]       coefficient_o,
  output logic      [bml_pkg::CW-1:0]               lfsr_length_o,
  output logic                                      done_res_o,
  output logic                                      bad_index_o
);

  localparam int unsigned FW  = bml_pkg::FIELD_BITS;
  localparam int unsigned PAW = bml_pkg::PAW;
  localparam int unsigned SAW = bml_pkg::SAW;
  localparam int unsigned CW  = bml_pkg::CW;
  localparam int unsigned MW  = bml_pkg::MW;
  localparam int unsigned TW  = bml_pkg::TW;
  localparam int unsigned NP  = bml_pkg::NPOLY;

  // ---------------- configuration registers
  logic [bml_pkg::CFG_W-1:0] poly_q;
  logic [MW-1:0]             deg_q;
  logic [TW-1:0]             tcap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= bml_pkg::POLY_RST;
      deg_q  <= bml_pkg::DEG_RST;
      tcap_q <= bml_pkg::TCAP_RST;
    end else if (cfg_we_i) begin
      case (bml_pkg::cfg_idx_e'(cfg_idx_i))
        bml_pkg::CFG_POLY:   poly_q <= cfg_data_i;
        bml_pkg::CFG_DEGREE: deg_q  <= cfg_data_i[MW-1:0];
        bml_pkg::CFG_TCAP:   tcap_q <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp m to 2..FIELD_BITS and t to 1..T_MAX.
  logic [MW-1:0]    m_eff;
  logic [TW-1:0]    t_eff;
  logic [CW-1:0]    t_w;
  logic [CW-1:0]    two_t;
  logic [FW:0]      one_sh;
  logic [FW-1:0]    elem_mask;

  always_comb begin
    m_eff = deg_q;
    if (deg_q < MW'(2)) m_eff = MW'(2);
    if (deg_q > MW'(FW)) m_eff = MW'(FW);
    t_eff = tcap_q;
    if (tcap_q < TW'(1)) t_eff = TW'(1);
    if (CW'(tcap_q) > CW'(bml_pkg::T_MAX)) t_eff = TW'(bml_pkg::T_MAX);
    t_w       = CW'(t_eff);
    two_t     = CW'({t_eff, 1'b0});
    one_sh    = (FW + 1)'(1) << m_eff;
    elem_mask = FW'(one_sh - 1'b1);
  end

  // ---------------- control and algorithm state
  bml_pkg::state_e state_q, state_d;

  logic          cbank_q,  cbank_d;
  logic [CW-1:0] len_q,    len_d;
  logic [CW-1:0] gap_q,    gap_d;
  logic [FW-1:0] lastd_q,  lastd_d;
  logic [CW-1:0] cnt_n_q,  cnt_n_d;
  logic [NP-1:0] vld0_q,   vld0_d;
  logic [NP-1:0] vld1_q,   vld1_d;
  logic          p1_q,     p1_d;
  logic          p2_q,     p2_d;
  logic          jdone_q,  jdone_d;
  logic          res_v_q,  res_v_d;

  // payload and working registers
  logic [FW-1:0] disc_q,   disc_d;
  logic [CW-1:0] idx_q,    idx_d;
  logic [CW-1:0] lim_q,    lim_d;
  logic          swap_q,   swap_d;
  logic [FW-1:0] base_q,   base_d;
  logic [FW-1:0] inv_q,    inv_d;
  logic [MW-1:0] step_q,   step_d;
  logic          phase_q,  phase_d;
  logic [FW-1:0] k_q,      k_d;
  logic [FW-1:0] prod_q,   prod_d;
  logic [PAW-1:0] j1_q,    j1_d;
  logic          u1_q,     u1_d;
  logic [PAW-1:0] j2_q,    j2_d;
  logic          u2_q,     u2_d;
  logic [FW-1:0] cdat2_q,  cdat2_d;
  logic          bad_q,    bad_d;
  logic          rv0_q,    rv1_q;
  logic          rz0_q,    rz1_q;
  logic [FW-1:0] coef_q,   coef_d;
  logic [CW-1:0] olen_q,   olen_d;
  logic          odone_q,  odone_d;
  logic          obad_q,   obad_d;

  // ---------------- memories
  logic           syn_we;
  logic [SAW-1:0] syn_waddr;
  logic [FW-1:0]  syn_wdata;
  logic [SAW-1:0] syn_raddr;
  logic [FW-1:0]  syn_rdata;

  logic [PAW-1:0] caddr, baddr, ra0, ra1;
  logic           pw_en;
  logic           pw_bank;
  logic [PAW-1:0] pw_addr;
  logic [FW-1:0]  pw_data;
  logic [FW-1:0]  rd0, rd1;

  bml_ram #(.DEPTH(bml_pkg::NSYN), .WIDTH(FW)) u_syn_ram (
    .clk_i   (clk_i),
    .we_i    (syn_we),
    .waddr_i (syn_waddr),
    .wdata_i (syn_wdata),
    .raddr_i (syn_raddr),
    .rdata_o (syn_rdata)
  );

  bml_ram #(.DEPTH(NP), .WIDTH(FW)) u_bank0_ram (
    .clk_i   (clk_i),
    .we_i    (pw_en && !pw_bank),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .raddr_i (ra0),
    .rdata_o (rd0)
  );

  bml_ram #(.DEPTH(NP), .WIDTH(FW)) u_bank1_ram (
    .clk_i   (clk_i),
    .we_i    (pw_en && pw_bank),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .raddr_i (ra1),
    .rdata_o (rd1)
  );

  // Route the C and B ports onto the physical banks.
  assign ra0 = cbank_q ? baddr : caddr;
  assign ra1 = cbank_q ? caddr : baddr;

  // An entry never written since restart reads as its start value: one at index 0.
  logic [FW-1:0] b0_dat, b1_dat, cdat, bdat;
  assign b0_dat = rv0_q ? rd0 : FW'(rz0_q);
  assign b1_dat = rv1_q ? rd1 : FW'(rz1_q);
  assign cdat   = cbank_q ? b1_dat : b0_dat;
  assign bdat   = cbank_q ? b0_dat : b1_dat;

  // ---------------- shared multiplier
  logic [FW-1:0] mul_a, mul_b, mul_y;
  assign mul_y = bml_pkg::gf_mul(mul_a, mul_b, poly_q, m_eff);

  // ---------------- next state
  logic          accept;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] len_eff;
  logic [CW-1:0] lim_c;
  logic          issue;
  logic [CW-1:0] jdiff;

  assign accept = start_i && (state_q == bml_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cbank_d = cbank_q;
    len_d   = len_q;
    gap_d   = gap_q;
    lastd_d = lastd_q;
    cnt_n_d = cnt_n_q;
    vld0_d  = vld0_q;
    vld1_d  = vld1_q;
    p1_d    = 1'b0;
    p2_d    = 1'b0;
    jdone_d = jdone_q;
    res_v_d = 1'b0;
    disc_d  = disc_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    swap_d  = swap_q;
    base_d  = base_q;
    inv_d   = inv_q;
    step_d  = step_q;
    phase_d = phase_q;
    k_d     = k_q;
    prod_d  = prod_q;
    j1_d    = j1_q;
    u1_d    = u1_q;
    j2_d    = j2_q;
    u2_d    = u2_q;
    cdat2_d = cdat2_q;
    bad_d   = bad_q;
    coef_d  = coef_q;
    olen_d  = olen_q;
    odone_d = odone_q;
    obad_d  = obad_q;

    syn_we    = 1'b0;
    syn_waddr = '0;
    syn_wdata = syndrome_value_i & elem_mask;
    syn_raddr = '0;
    caddr     = '0;
    baddr     = '0;
    pw_en     = 1'b0;
    pw_bank   = cbank_q;
    pw_addr   = j2_q;
    pw_data   = cdat2_q ^ (u2_q ? prod_q : '0);
    mul_a     = cdat;
    mul_b     = syn_rdata;
    n_eff     = '0;
    len_eff   = '0;
    lim_c     = '0;
    issue     = 1'b0;
    jdiff     = '0;
    busy_o    = (state_q != bml_pkg::ST_IDLE);

    case (state_q)
      bml_pkg::ST_IDLE: begin
        caddr = PAW'(t_w - CW'(coeff_index_i));
        if (accept) begin
          if (bml_pkg::req_e'(req_type_i) == bml_pkg::REQ_READ) begin
            bad_d   = CW'(coeff_index_i) > t_w;
            state_d = bml_pkg::ST_READ;
          end else begin
            n_eff   = cnt_n_q;
            len_eff = len_q;
            if (start_req_i) begin
              // restart: C=1, B=1, L=0, gap=1, b=1
              vld0_d  = '0;
              vld1_d  = '0;
              len_d   = '0;
              gap_d   = CW'(1);
              lastd_d = FW'(1);
              cnt_n_d = '0;
              n_eff   = '0;
              len_eff = '0;
            end
            if (n_eff < two_t) begin
              syn_we    = 1'b1;
              syn_waddr = n_eff[SAW-1:0];
              disc_d    = syn_wdata;
              lim_c     = len_eff;
              if (n_eff < lim_c) lim_c = n_eff;
              if (t_w < lim_c) lim_c = t_w;
              lim_d   = lim_c;
              idx_d   = CW'(1);
              state_d = bml_pkg::ST_DISC;
            end
          end
        end
      end

      bml_pkg::ST_READ: begin
        coef_d  = bad_q ? '0 : cdat;
        obad_d  = bad_q;
        olen_d  = len_q;
        odone_d = cnt_n_q >= two_t;
        res_v_d = 1'b1;
        state_d = bml_pkg::ST_IDLE;
      end

      bml_pkg::ST_DISC: begin
        // issue reads of C[i] and S[n-i]; multiply; fold into d
        issue     = idx_q <= lim_q;
        caddr     = idx_q[PAW-1:0];
        syn_raddr = SAW'(cnt_n_q - idx_q);
        if (issue) idx_d = idx_q + CW'(1);
        p1_d  = issue;
        p2_d  = p1_q;
        mul_a = cdat;
        mul_b = syn_rdata;
        if (p1_q) prod_d = mul_y;
        if (p2_q) disc_d = disc_q ^ prod_q;
        if (!issue && !p1_q && !p2_q) state_d = bml_pkg::ST_DECIDE;
      end

      bml_pkg::ST_DECIDE: begin
        swap_d = {1'b0, len_q, 1'b0} <= {1'b0, 1'b0, cnt_n_q};
        if (disc_q == '0) begin
          gap_d   = gap_q + CW'(1);
          cnt_n_d = cnt_n_q + CW'(1);
          state_d = bml_pkg::ST_IDLE;
        end else begin
          base_d  = lastd_q;
          inv_d   = FW'(1);
          step_d  = MW'(1);
          phase_d = 1'b0;
          state_d = bml_pkg::ST_INV;
        end
      end

      bml_pkg::ST_INV: begin
        // b^(2^m-2) as the product of b^(2^i), i = 1..m-1
        if (!phase_q) begin
          mul_a   = base_q;
          mul_b   = base_q;
          base_d  = mul_y;
          phase_d = 1'b1;
        end else begin
          mul_a   = inv_q;
          mul_b   = base_q;
          inv_d   = mul_y;
          phase_d = 1'b0;
          if (step_q == m_eff - MW'(1)) begin
            state_d = bml_pkg::ST_KMUL;
          end else begin
            step_d = step_q + MW'(1);
          end
        end
      end

      bml_pkg::ST_KMUL: begin
        mul_a   = disc_q;
        mul_b   = inv_q;
        k_d     = mul_y;
        idx_d   = CW'(bml_pkg::T_MAX);
        jdone_d = 1'b0;
        state_d = bml_pkg::ST_CORR;
      end

      bml_pkg::ST_CORR: begin
        // walk j from T_MAX down: newC[j] = C[j] ^ k*B[j-gap] for gap <= j <= t
        issue = !jdone_q;
        jdiff = idx_q - gap_q;
        caddr = idx_q[PAW-1:0];
        baddr = jdiff[PAW-1:0];
        if (issue) begin
          if (idx_q == '0) jdone_d = 1'b1;
          else idx_d = idx_q - CW'(1);
        end
        p1_d = issue;
        j1_d = idx_q[PAW-1:0];
        u1_d = (idx_q >= gap_q) && (idx_q <= t_w);
        p2_d    = p1_q;
        mul_a   = k_q;
        mul_b   = bdat;
        prod_d  = mul_y;
        cdat2_d = cdat;
        j2_d    = j1_q;
        u2_d    = u1_q;
        if (p2_q) begin
          pw_en   = 1'b1;
          pw_bank = swap_q ? !cbank_q : cbank_q;
          if (pw_bank) vld1_d[j2_q] = 1'b1;
          else vld0_d[j2_q] = 1'b1;
        end
        if (jdone_q && !p1_q && !p2_q) begin
          if (swap_q) begin
            len_d   = cnt_n_q + CW'(1) - len_q;
            lastd_d = disc_q;
            gap_d   = CW'(1);
            cbank_d = !cbank_q;
          end else begin
            gap_d = gap_q + CW'(1);
          end
          cnt_n_d = cnt_n_q + CW'(1);
          state_d = bml_pkg::ST_IDLE;
        end
      end

      default: state_d = bml_pkg::ST_IDLE;
    endcase
  end

  // ---------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bml_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbank_q <= 1'b0;
      len_q   <= '0;
      gap_q   <= CW'(1);
      lastd_q <= FW'(1);
      cnt_n_q <= '0;
      vld0_q  <= '0;
      vld1_q  <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      jdone_q <= 1'b1;
      res_v_q <= 1'b0;
    end else begin
      cbank_q <= cbank_d;
      len_q   <= len_d;
      gap_q   <= gap_d;
      lastd_q <= lastd_d;
      cnt_n_q <= cnt_n_d;
      vld0_q  <= vld0_d;
      vld1_q  <= vld1_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      jdone_q <= jdone_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    disc_q  <= disc_d;
    idx_q   <= idx_d;
    lim_q   <= lim_d;
    swap_q  <= swap_d;
    base_q  <= base_d;
    inv_q   <= inv_d;
    step_q  <= step_d;
    phase_q <= phase_d;
    k_q     <= k_d;
    prod_q  <= prod_d;
    j1_q    <= j1_d;
    u1_q    <= u1_d;
    j2_q    <= j2_d;
    u2_q    <= u2_d;
    cdat2_q <= cdat2_d;
    bad_q   <= bad_d;
    coef_q  <= coef_d;
    olen_q  <= olen_d;
    odone_q <= odone_d;
    obad_q  <= obad_d;
    // track valid bits and the zero index beside each bank's read data
    rv0_q   <= vld0_q[ra0];
    rv1_q   <= vld1_q[ra1];
    rz0_q   <= (ra0 == '0);
    rz1_q   <= (ra1 == '0);
  end

  assign res_valid_o   = res_v_q;
  assign coefficient_o = coef_q;
  assign lfsr_length_o = olen_q;
  assign done_res_o    = odone_q;
  assign bad_index_o   = obad_q;

endmodule

`default_nettype wire

// ----- rtl/bml_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module bml_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 13
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- bench/berlekamp_massey_locator_core_tb.sv -----
// Testbench for the Berlekamp-Massey locator core: a scoreboard that predicts reads, plus drivers.
`default_nettype none

module berlekamp_massey_locator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Locator tracker: mirrors the connection polynomial run, one iteration per push beat before done,
  // and keeps the read beats it expects back in order.
  class bm_scoreboard;
    typedef struct {
      logic [12:0] coef;
      logic [8:0]  len;
      logic        done;
      logic        bad;
    } locator_read_t;

    locator_read_t expected_q[$];
    int          errors;
    bit [13:0]   poly_r;
    bit [3:0]    deg_r;
    bit [7:0]    tcap_r;
    bit [12:0]   conn[129];
    bit [12:0]   back[129];
    bit [12:0]   saved[129];
    bit [12:0]   synd[256];
    int          len_l;
    int          gap_l;
    int          last_d;
    int          taken;

    function new();
      errors = 0;
      poly_r = 14'd8219;
      deg_r  = 4'd13;
      tcap_r = 8'd128;
      restart();
    endfunction

    function void restart();
      foreach (conn[i]) begin
        conn[i] = '0;
        back[i] = '0;
      end
      conn[0] = 13'd1;
      back[0] = 13'd1;
      len_l  = 0;
      gap_l  = 1;
      last_d = 1;
      taken  = 0;
    endfunction

    function int field_m();
      int m;
      m = int'(deg_r);
      if (m < 2) m = 2;
      if (m > 13) m = 13;
      return m;
    endfunction

    function int cap_t();
      int t;
      t = int'(tcap_r);
      if (t < 1) t = 1;
      if (t > 128) t = 128;
      return t;
    endfunction

    function int fmul(int a, int b);
      int m;
      int mask;
      int r;
      m = field_m();
      mask = (1 << m) - 1;
      a &= mask;
      b &= mask;
      r = 0;
      for (int i = m; i > 0; i--) begin
        r = r << 1;
        if ((r >> m) & 1) r ^= int'(poly_r);
        r &= mask;
        if ((b >> (i - 1)) & 1) r ^= a;
      end
      return r;
    endfunction

    // a^(2^m - 2); zero maps to zero
    function int finv(int a);
      int e;
      int acc;
      int base;
      e = (1 << field_m()) - 2;
      acc = 1;
      base = a & ((1 << field_m()) - 1);
      while (e != 0) begin
        if (e & 1) acc = fmul(acc, base);
        base = fmul(base, base);
        e >>= 1;
      end
      return acc;
    endfunction

    function void iterate(int s);
      int t;
      int n;
      int d;
      int k;
      t = cap_t();
      n = taken;
      synd[n] = 13'(s);
      d = s;
      for (int i = 1; i <= len_l && i <= n && i <= t; i++) begin
        d ^= fmul(int'(conn[i]), int'(synd[n - i]));
      end
      if (d == 0) begin
        gap_l++;
      end else begin
        saved = conn;
        if (last_d != 0) begin
          k = fmul(d, finv(last_d));
          for (int i = 0; i + gap_l <= t; i++) begin
            conn[i + gap_l] ^= 13'(fmul(k, int'(back[i])));
          end
        end
        if (2 * len_l <= n) begin
          len_l  = n + 1 - len_l;
          back   = saved;
          last_d = d;
          gap_l  = 1;
        end else begin
          gap_l++;
        end
      end
      gap_l &= 'h1FF;
      taken = n + 1;
    endfunction

    function void write_reg(bml_pkg::cfg_idx_e idx, bit [13:0] data);
      case (idx)
        bml_pkg::CFG_POLY:   poly_r = data;
        bml_pkg::CFG_DEGREE: deg_r  = data[3:0];
        bml_pkg::CFG_TCAP:   tcap_r = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_beat(bml_pkg::req_e req, bit st, bit [12:0] syn, bit [7:0] idx);
      int t;
      locator_read_t e;
      t = cap_t();
      if (req == bml_pkg::REQ_PUSH) begin
        if (st) restart();
        if (taken < 2 * t) iterate(int'(syn) & ((1 << field_m()) - 1));
      end else begin
        e.bad  = (int'(idx) > t);
        e.coef = e.bad ? 13'd0 : conn[t - int'(idx)];
        e.len  = 9'(len_l);
        e.done = (taken >= 2 * t);
        expected_q.push_back(e);
      end
    endfunction

    function void check_beat(logic [12:0] coef, logic [8:0] len, logic done, logic bad);
      locator_read_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with no read outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (coef !== e.coef) begin
        $error("coefficient: expected %0d, actual %0d", e.coef, coef);
        errors++;
      end
      if (len !== e.len) begin
        $error("lfsr_length: expected %0d, actual %0d", e.len, len);
        errors++;
      end
      if (done !== e.done) begin
        $error("done_res: expected %0d, actual %0d", e.done, done);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("bad_index: expected %0d, actual %0d", e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start_i;
  logic                           busy_o;
  logic                           req_type_i;
  logic                           start_req_i;
  logic [bml_pkg::FIELD_BITS-1:0] syndrome_value_i;
  logic [bml_pkg::TW-1:0]         coeff_index_i;
  logic                           cfg_we_i;
  logic [1:0]                     cfg_idx_i;
  logic [bml_pkg::CFG_W-1:0]      cfg_data_i;
  logic                           res_valid_o;
  logic [bml_pkg::FIELD_BITS-1:0] coefficient_o;
  logic [bml_pkg::CW-1:0]         lfsr_length_o;
  logic                           done_res_o;
  logic                           bad_index_o;

  bm_scoreboard sb;
  int           beats_sent;
  int           burst_left;

  berlekamp_massey_locator_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .start_req_i, .syndrome_value_i,
    .coeff_index_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .res_valid_o, .coefficient_o,
    .lfsr_length_o, .done_res_o, .bad_index_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Check every result strobe; values read here are the ones held before this edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_beat(coefficient_o, lfsr_length_o, done_res_o, bad_index_o);
    end
  end

  // Drive one request and hold it until the core takes it. Bursts keep start high
  // back to back; at the end of a burst drop start for a random gap.
  task automatic send_beat(bml_pkg::req_e req, bit st, bit [12:0] syn, bit [7:0] idx);
    start_i          <= 1'b1;
    req_type_i       <= req;
    start_req_i      <= st;
    syndrome_value_i <= syn;
    coeff_index_i    <= idx;
    do @(posedge clk_i); while (busy_o);
    sb.note_beat(req, st, syn, idx);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      // occasionally a long burst with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Let every outstanding read come back, then wait out a worst-case push so the
  // core is idle before anything touches the registers.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(bml_pkg::cfg_idx_e idx, bit [13:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_field(bit [13:0] poly, bit [3:0] deg, bit [7:0] tcap);
    write_reg(bml_pkg::CFG_POLY, poly);
    write_reg(bml_pkg::CFG_DEGREE, {10'd0, deg});
    write_reg(bml_pkg::CFG_TCAP, {6'd0, tcap});
  endtask

  function automatic bit [12:0] rand_syndrome();
    // plenty of zeros so the zero-discrepancy path gets hit
    return ($urandom_range(0, 3) == 0) ? 13'd0 : 13'($urandom_range(0, 8191));
  endfunction

  // One decode: a push that mostly restarts the run, up to 2t syndromes (sometimes a few past
  // done, which are dropped), reads spread over the locator, some out-of-range indices, and a bit of noise.
  task automatic run_decode(int npush);
    int t;
    t = sb.cap_t();
    for (int i = 0; i < npush; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_beat(bml_pkg::REQ_READ, 1'($urandom), rand_syndrome(),
                  8'($urandom_range(0, 255)));
      end
      send_beat(bml_pkg::REQ_PUSH,
                (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0),
                rand_syndrome(), 8'($urandom));
    end
    repeat ($urandom_range(2, 6)) begin
      send_beat(bml_pkg::REQ_READ, 1'($urandom), 13'($urandom),
                ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, t)));
    end
  endtask

  task automatic run_phase(int ndecodes);
    int t;
    repeat (ndecodes) begin
      t = sb.cap_t();
      run_decode(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * t + 3) : 2 * t + 1);
    end
    settle();
  endtask

  initial begin
    sb               = new();
    beats_sent       = 0;
    burst_left       = 0;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    req_type_i       = bml_pkg::REQ_PUSH;
    start_req_i      = 1'b0;
    syndrome_value_i = '0;
    coeff_index_i    = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = bml_pkg::CFG_POLY;
    cfg_data_i       = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults (m=13, t=128); push without start, field extremes,
    // read indices at both ends and past t.
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'h1FFF, 8'd0);
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'd0, 8'd0);
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'd1, 8'd0);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd0);
    send_beat(bml_pkg::REQ_READ, 1'b1, 13'h1FFF, 8'd128);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd127);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd129);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd255);
    send_beat(bml_pkg::REQ_PUSH, 1'b1, 13'h1555, 8'hFF);
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'h0AAA, 8'd0);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd126);
    settle();

    // Smallest field, capability zero clamps to one; pushes past done get dropped.
    set_field(14'd7, 4'd2, 8'd0);
    send_beat(bml_pkg::REQ_PUSH, 1'b1, 13'h1FFF, 8'd0);
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'd2, 8'd0);
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'd3, 8'd0);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd0);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd1);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd2);
    run_phase(8);

    // Degree 15 clamps to 13, a degree of zero clamps to two.
    set_field(14'h201B, 4'd15, 8'd5);
    run_phase(6);
    set_field(14'h0000, 4'd0, 8'd3);
    run_phase(6);
    // Reducible polynomial, all ones.
    set_field(14'h3FFF, 4'd13, 8'd8);
    run_phase(4);
    // Capability changed mid-run: same state, t grows from 8 to 10.
    write_reg(bml_pkg::CFG_NONE, 14'h3FFF);
    write_reg(bml_pkg::CFG_TCAP, 14'd10);
    send_beat(bml_pkg::REQ_PUSH, 1'b0, 13'h0123, 8'd0);
    send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'd10);
    run_phase(3);

    // Largest capability: t of 255 clamps to 128, one long run with partial fill.
    set_field(14'h201B, 4'd13, 8'd255);
    repeat (60) send_beat(bml_pkg::REQ_PUSH, 1'b0, rand_syndrome(), 8'($urandom));
    repeat (6) send_beat(bml_pkg::REQ_READ, 1'b0, 13'd0, 8'($urandom_range(0, 255)));
    settle();

    // Random fields and small capabilities until the beat budget is spent.
    while (beats_sent < 600) begin
      set_field(14'($urandom), 4'($urandom), 8'($urandom_range(0, 12)));
      run_phase($urandom_range(1, 4));
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/bml_pkg.sv
rtl/bml_ram.sv
rtl/berlekamp_massey_locator_core.sv
bench/berlekamp_massey_locator_core_tb.sv
